@@ rtl/lkvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and controller/datapath interface types for the LRU
// key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int CAP_W         = 5;

   localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   typedef struct packed {
      logic load;
      logic search;
      logic update;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic is_set;
   } status_type;

endpackage

@@ rtl/lru_key_value_cache_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A get passes through the search, update and read states and returns its
// result from the result register; a set ends after update, returning nothing.
// A new request is taken only in idle, after the search, rank update and value
// RAM read sequence; a get waits in read until the response slot is free.
// Reset: fill count and ranks clear, capacity returns to 16; no clearing pass.
module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,  // lookup_key[31:0], store_value[63:32]
   input  logic             req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,  // read_value[31:0]
   output logic             rsp_tuser,  // hit
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_type  (req_tuser),
      .req_key   (req_tdata[31:0]),
      .req_value (req_tdata[63:32]),
      .csr_wr    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_hit   (rsp_tuser),
      .rsp_value (rsp_tdata)
   );

endmodule

@@ rtl/lkvc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lkvc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key cells with parallel compare, recency ranks, fill count, capacity
// register, value RAM and the result register.
// ----------------------------------------------------------------------------
module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_type,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               csr_wr,
   input  logic [CAP_W-1:0]   csr_data,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_value
);

   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic               req_type_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [VALUE_W-1:0] req_value_ff;
   logic [KEY_W-1:0]   key_ff [DEPTH];
   logic [IDX_W-1:0]   age_ff [DEPTH];
   logic [IDX_W-1:0]   age_in [DEPTH];
   logic [DEPTH-1:0]   match_ff;
   logic [DEPTH-1:0]   match_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;
   logic               hit;
   logic               do_fill;
   logic [DEPTH-1:0]   filled;
   logic [DEPTH-1:0]   victim;
   logic [DEPTH-1:0]   free_slot;
   logic [DEPTH-1:0]   sel;
   logic [IDX_W-1:0]   sel_idx;
   logic [CNT_W-1:0]   old_age;
   logic [CNT_W-1:0]   sel_age;
   logic [CNT_W-1:0]   last_rank;
   logic [VALUE_W-1:0] ram_rdata;

   assign cap_ext   = CMP_W'(cap_ff);
   assign eff_cap   = (cap_ext == '0) ? CMP_W'(1) :
                      (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full      = CMP_W'(fill_ff) >= eff_cap;
   assign hit       = |match_ff;
   assign do_fill   = req_type_ff && !hit && !full;
   assign last_rank = fill_ff - CNT_W'(1);

   always_comb begin
      sel_idx = '0;
      sel_age = '0;
      for (int i = 0; i < DEPTH; i++) begin
         filled[i]    = CNT_W'(i) < fill_ff;
         match_in[i]  = filled[i] && (key_ff[i] == req_key_ff);
         victim[i]    = filled[i] && (CNT_W'(age_ff[i]) == last_rank);
         free_slot[i] = CNT_W'(i) == fill_ff;
      end
      sel = hit ? match_ff : (full ? victim : free_slot);
      for (int i = 0; i < DEPTH; i++) begin
         if (sel[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
            sel_age = sel_age | CNT_W'(age_ff[i]);
         end
      end
      old_age = do_fill ? fill_ff : sel_age;
      fill_in = do_fill ? fill_ff + CNT_W'(1) : fill_ff;
      for (int i = 0; i < DEPTH; i++) begin
         age_in[i] = age_ff[i];
         if (sel[i]) begin
            age_in[i] = '0;
         end else if (filled[i] && (CNT_W'(age_ff[i]) < old_age)) begin
            age_in[i] = age_ff[i] + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cap_ff  <= CAPACITY_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         if (csr_wr) begin
            cap_ff <= csr_data;
         end
         if (cmd.update && (req_type_ff || hit)) begin
            fill_ff <= fill_in;
            for (int i = 0; i < DEPTH; i++) begin
               age_ff[i] <= age_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff  <= req_type;
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
      if (cmd.search) begin
         match_ff <= match_in;
      end
      if (cmd.update && req_type_ff) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (sel[i]) begin
               key_ff[i] <= req_key_ff;
            end
         end
      end
      if (cmd.respond) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= hit ? ram_rdata : MISS_VALUE;
      end
   end

   lkvc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.update && req_type_ff),
      .wr_addr (sel_idx),
      .wr_data (req_value_ff),
      .rd_en   (cmd.update && !req_type_ff),
      .rd_addr (sel_idx),
      .rd_data (ram_rdata)
   );

   assign status.is_set = (req_type_ff == REQ_SET);
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value     = rsp_value_ff;

endmodule

@@ rtl/lkvc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: accept, search, update, read, and result handoff.
// ----------------------------------------------------------------------------
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SEARCH,
      UPDATE,
      READ
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.load    = (state_ff == IDLE) && req_tvalid;
      cmd.search  = (state_ff == SEARCH);
      cmd.update  = (state_ff == UPDATE);
      cmd.respond = (state_ff == READ) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               state_ff <= UPDATE;
            end
            UPDATE: begin
               state_ff <= status.is_set ? IDLE : READ;
            end
            READ: begin
               if (slot_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ test/lru_key_value_cache_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Runs get and set requests through the LRU key-value cache and checks each
// lookup against a behavioral LRU store in the bench or a typed table row: a
// directed table of edge keys and capacity corner cases, then random traffic
// over a small key pool per capacity setting; random stalls on both streams.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_tb
   import lkvc_pkg::*;
();

   localparam int          DEPTH        = DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          POOL_SIZE    = DEPTH + 4;
   localparam int          PHASE_ITEMS  = 105;

   typedef enum logic [1:0] {ROW_GET, ROW_SET, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value;
   } lookup_result_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] data;
      bit                 typed;
      logic               hit;
      logic [VALUE_W-1:0] value;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_SET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'h0000_0000, 32'd2,         1'b0, 1'b0, 32'h0},
      '{ROW_SET, 32'h0000_0005, 32'd55,        1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'h0000_0000, 32'd0,         1'b0, 1'b0, 32'h0},
      '{ROW_SET, 32'h0000_0006, 32'd66,        1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'h0000_0000, 32'd31,        1'b0, 1'b0, 32'h0},
      '{ROW_SET, 32'h0000_0007, 32'd77,        1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
   };

   localparam logic [CAP_W-1:0] PHASE_CAPS [11] = '{
      5'd1, 5'd4, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2, 5'd0, 5'd12, 5'd31, 5'd16
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [63:0]        req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [31:0]        rsp_tdata;
   logic               rsp_tuser;
   logic               csr_valid;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_data;

   logic [KEY_W-1:0]   cached_keys   [DEPTH];
   logic [VALUE_W-1:0] cached_values [DEPTH];
   int unsigned        recency_rank  [DEPTH];
   int unsigned        filled_entries;
   logic [CAP_W-1:0]   capacity_reg;

   lookup_result_type  pending_lookups [$];
   int unsigned        mismatch_count;
   int unsigned        cycle_count;
   bit                 random_phase;
   bit                 hold_done;

   lru_key_value_cache_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // make entry idx most recent; entries more recent than it age by one
   function automatic void promote(int unsigned idx);
      int unsigned old_rank;
      old_rank = recency_rank[idx];
      for (int unsigned i = 0; i < filled_entries; i++) begin
         if (i != idx && recency_rank[i] < old_rank) recency_rank[i]++;
      end
      recency_rank[idx] = 0;
   endfunction

   function automatic bit lru_access(logic kind, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] data,
                                     output lookup_result_type res);
      int unsigned idx;
      int unsigned limit;
      idx = DEPTH;
      res.hit   = 1'b0;
      res.value = MISS_VALUE;
      for (int unsigned i = 0; i < filled_entries; i++) begin
         if (idx == DEPTH && cached_keys[i] == key) idx = i;
      end
      if (kind == REQ_GET) begin
         if (idx < DEPTH) begin
            res.hit   = 1'b1;
            res.value = cached_values[idx];
            promote(idx);
         end
         return 1'b1;
      end
      if (idx == DEPTH) begin
         limit = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
         if (filled_entries < limit) begin
            idx = filled_entries;
            recency_rank[idx] = filled_entries;
            filled_entries++;
         end else begin
            idx = 0;
            for (int unsigned i = 1; i < filled_entries; i++) begin
               if (recency_rank[i] > recency_rank[idx]) idx = i;
            end
         end
         cached_keys[idx] = key;
      end
      cached_values[idx] = data;
      promote(idx);
      return 1'b0;
   endfunction

   function automatic void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] data,
                               bit typed, lookup_result_type typed_res);
      lookup_result_type res;
      int unsigned       r;
      int unsigned       gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {data, key};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (lru_access(kind, key, data, res)) pending_lookups.push_back(typed ? typed_res : res);
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(15, 50);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain outstanding lookups and any set still in flight, then transfer
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (csr_ready !== 1'b1);
      capacity_reg = cap;
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type       row;
      logic [KEY_W-1:0]   key_pool [POOL_SIZE];
      logic [KEY_W-1:0]   key;
      int unsigned        span;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_GET;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      filled_entries = 0;
      capacity_reg   = CAPACITY_RESET;
      foreach (recency_rank[i]) recency_rank[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[n]) begin
         row = DIRECTED_ROWS[n];
         if (row.kind == ROW_CSR) begin
            write_capacity(row.data[CAP_W-1:0]);
         end else begin
            send_request((row.kind == ROW_SET) ? REQ_SET : REQ_GET, row.key, row.data,
                         row.typed, lookup_result_type'{row.hit, row.value});
         end
      end

      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      foreach (PHASE_CAPS[p]) begin
         write_capacity(PHASE_CAPS[p]);
         random_phase = 1'b1;
         span = (PHASE_CAPS[p] == 0) ? 5 :
                ((PHASE_CAPS[p] > DEPTH) ? POOL_SIZE : PHASE_CAPS[p] + 4);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, span - 1)];
            else key = $urandom;
            send_request($urandom_range(0, 1) ? REQ_SET : REQ_GET, key, $urandom,
                         1'b0, lookup_result_type'('0));
         end
      end

      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : rsp_side
      logic        level;
      int unsigned span;
      int unsigned r;
      forever begin
         r = $urandom_range(0, 19);
         if (random_phase && !hold_done) begin
            // long hold so the request side backs up
            level     = 1'b0;
            span      = 400;
            hold_done = 1'b1;
         end else if (r < 6) begin
            level = 1'b1;
            span  = $urandom_range(1, 40);
         end else if (r < 18) begin
            level = $urandom_range(0, 1);
            span  = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span  = $urandom_range(20, 60);
         end
         rsp_tready <= level;
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_lookups.size() == 0) begin
            log_mismatch($sformatf("unexpected transfer: hit=%0b value=%h",
                                   rsp_tuser, rsp_tdata));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tuser !== want.hit || rsp_tdata !== want.value) begin
               log_mismatch($sformatf("lookup: expected hit=%0b value=%h, got hit=%0b value=%h",
                                      want.hit, want.value, rsp_tuser, rsp_tdata));
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_datapath.sv
rtl/lkvc_ctrl.sv
rtl/lru_key_value_cache_unit.sv
test/lru_key_value_cache_unit_tb.sv
